@@ sv/adaptive_window_velocity_estimator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive window velocity estimator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_WINDOW_VELOCITY_ESTIMATOR_DEFINES_SVH
`define ADAPTIVE_WINDOW_VELOCITY_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define AWVE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("awve check failed");

// next-cycle implication
`define AWVE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("awve check failed");

`endif

@@ sv/awve_pkg.sv @@
// ----------------------------------------------------------------------------
// awve_pkg
// Shared constants, register indexes, config struct and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package awve_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 16;
  localparam int unsigned POS_WIDTH_DEF  = 32;
  localparam int unsigned VEL_WIDTH      = 32;
  localparam int unsigned CFG_WIDTH      = 31;
  localparam int unsigned LEN_WIDTH      = 5;
  localparam int unsigned NOISE_WIDTH    = 31;
  localparam int unsigned RATE_WIDTH     = 20;

  typedef enum logic [1:0] {
    CFG_FIT_MODE = 2'd0,
    CFG_WIN_LEN  = 2'd1,
    CFG_NOISE    = 2'd2,
    CFG_RATE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                   fit_mode;
    logic [LEN_WIDTH-1:0]   window_length;
    logic [NOISE_WIDTH-1:0] noise_bound;
    logic [RATE_WIDTH-1:0]  sample_rate;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fit_mode:      1'b1,
    window_length: 5'd15,
    noise_bound:   31'd7,
    sample_rate:   20'd1000
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_WRAP, ST_RD_I, ST_GOT_I, ST_UPD, ST_BND, ST_BND_W,
    ST_RD_J, ST_GOT_J, ST_MUL_J, ST_CMP_J, ST_ACC, ST_VEL, ST_VEL_W,
    ST_DIV, ST_FIN, ST_OUT
  } state_e;

endpackage

`default_nettype wire

@@ sv/awve_hist.sv @@
// ----------------------------------------------------------------------------
// awve_hist
// Position history memory, one write and one registered read port; entries
// never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module awve_hist #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DW-1:0]    rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ sv/awve_mul.sv @@
// ----------------------------------------------------------------------------
// awve_mul
// Shared signed-by-unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module awve_mul #(
  parameter int unsigned AW = 40,
  parameter int unsigned BW = 20
) (
  input  wire logic                 clk_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic        [BW-1:0] b_i,
  output logic signed [AW+BW:0]     p_o
);

  logic signed [AW+BW:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * $signed({1'b0, b_i});
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ sv/awve_core.sv @@
// ----------------------------------------------------------------------------
// awve_core
// Window search sequencer and datapath around the shared multiplier, plus
// the bit-serial divider for the final velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module awve_core
  import awve_pkg::*;
#(
  parameter int unsigned MAX_WINDOW     = MAX_WINDOW_DEF,
  parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfg_t                      cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [POSITION_WIDTH-1:0] position_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [VEL_WIDTH-1:0]           velocity_o
);

  localparam int unsigned CW  = $clog2(MAX_WINDOW);
  localparam int unsigned IW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW  = POSITION_WIDTH + 2 * CW;
  localparam int unsigned AW  = (SW > 32) ? SW : 32;
  localparam int unsigned BW  = (3 * CW > RATE_WIDTH) ? 3 * CW : RATE_WIDTH;
  localparam int unsigned PRW = AW + BW + 1;
  localparam int unsigned DCW = $clog2(PRW + 1);
  localparam int unsigned LW  = (IW > LEN_WIDTH) ? IW : LEN_WIDTH;

  state_e state_q, state_d;

  logic [IW-1:0]         i_q, i_d, j_q, j_d, wi_q, wi_d;
  logic signed [AW-1:0]  p0_q, p0_d, pi_q, pi_d, a_q, a_d, sb_q, sb_d;
  logic signed [AW-1:0]  scur_q, scur_d, sacc_q, sacc_d;
  logic [BW-1:0]         qb_q, qb_d, t_q, t_d, qcur_q, qcur_d, qacc_q, qacc_d;
  logic signed [PRW-1:0] bound_q, bound_d, t1_q, t1_d;
  logic [PRW-1:0]        num_q, num_d;
  logic [BW-1:0]         rem_q, rem_d;
  logic [VEL_WIDTH-1:0]  quo_q, quo_d, vel_q, vel_d;
  logic                  big_q, big_d, neg_q, neg_d;
  logic [DCW-1:0]        cnt_q, cnt_d;

  logic [IW-1:0]         size;
  logic [LW-1:0]         wl_ext;
  logic                  hist_we;
  logic [CW-1:0]         hist_raddr;
  logic [POSITION_WIDTH-1:0] hist_rdata;
  logic signed [AW-1:0]  rd_pos;
  logic signed [AW-1:0]  mul_a;
  logic [BW-1:0]         mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [PRW:0]   dev;
  logic [PRW:0]          dev_mag;
  logic                  dev_big;
  logic signed [AW-1:0]  sb_new;
  logic [BW:0]           rem_sh;
  logic                  ovf;

  function automatic logic [CW-1:0] hist_addr(input logic [IW-1:0] newest,
                                              input logic [IW-1:0] back,
                                              input logic [IW-1:0] sz);
    logic [IW:0] diff;
    diff = {1'b0, newest} - {1'b0, back};
    if (diff[IW]) begin
      diff = diff + {1'b0, sz};
    end
    return diff[CW-1:0];
  endfunction

  awve_hist #(
    .DEPTH (MAX_WINDOW),
    .DW    (POSITION_WIDTH)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (wi_q[CW-1:0]),
    .wdata_i (p0_q[POSITION_WIDTH-1:0]),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  awve_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    wl_ext = LW'(cfg_i.window_length);
    if (wl_ext < LW'(2)) begin
      size = IW'(2);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      size = IW'(MAX_WINDOW);
    end else begin
      size = wl_ext[IW-1:0];
    end
  end

  assign rd_pos  = AW'($signed(hist_rdata));
  assign sb_new  = sb_q + a_q - $signed(prod[AW-1:0]);
  assign dev     = {t1_q[PRW-1], t1_q} - {prod[PRW-1], prod};
  assign dev_mag = dev[PRW] ? -dev : dev;
  assign dev_big = dev_mag > {1'b0, bound_q};
  assign rem_sh  = {rem_q, num_q[PRW-1]};
  assign ovf     = big_q | quo_q[VEL_WIDTH-1];

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_WRAP;
      ST_WRAP:  if (wi_q < size) state_d = ST_RD_I;
      ST_RD_I:  state_d = ST_GOT_I;
      ST_GOT_I: state_d = ST_UPD;
      ST_UPD:   state_d = ST_BND;
      ST_BND:   state_d = ST_BND_W;
      ST_BND_W: state_d = (i_q == IW'(1)) ? ST_ACC : ST_RD_J;
      ST_RD_J:  state_d = ST_GOT_J;
      ST_GOT_J: state_d = ST_MUL_J;
      ST_MUL_J: state_d = ST_CMP_J;
      ST_CMP_J: begin
        if (dev_big) begin
          state_d = ST_VEL;
        end else if (j_q + IW'(1) == i_q) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_RD_J;
        end
      end
      ST_ACC:   state_d = (i_q + IW'(1) == size) ? ST_VEL : ST_RD_I;
      ST_VEL:   state_d = ST_VEL_W;
      ST_VEL_W: state_d = ST_DIV;
      ST_DIV:   if (cnt_q == DCW'(1)) state_d = ST_FIN;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    i_d = i_q; j_d = j_q; wi_d = wi_q;
    p0_d = p0_q; pi_d = pi_q; a_d = a_q; sb_d = sb_q;
    scur_d = scur_q; sacc_d = sacc_q;
    qb_d = qb_q; t_d = t_q; qcur_d = qcur_q; qacc_d = qacc_q;
    bound_d = bound_q; t1_d = t1_q; num_d = num_q; rem_d = rem_q;
    quo_d = quo_q; big_d = big_q; neg_d = neg_q; cnt_d = cnt_q; vel_d = vel_q;
    hist_we    = 1'b0;
    hist_raddr = '0;
    mul_a      = '0;
    mul_b      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        p0_d = AW'($signed(position_i));
        if (in_valid_i) begin
          wi_d = wi_q + IW'(1);
        end
      end
      ST_WRAP: begin
        if (wi_q >= size) begin
          wi_d = wi_q - size;
        end else begin
          hist_we = 1'b1;
          i_d     = IW'(1);
          a_d     = p0_q;
          sb_d    = '0;
          qb_d    = '0;
          t_d     = '0;
          sacc_d  = '0;
          qacc_d  = BW'(1);
        end
      end
      ST_RD_I: begin
        hist_raddr = hist_addr(wi_q, i_q, size);
      end
      ST_GOT_I: begin
        pi_d  = rd_pos;
        mul_a = rd_pos;
        mul_b = BW'(i_q);
        t_d   = t_q + BW'(i_q);
        qb_d  = qb_q + t_q + BW'(i_q);
      end
      ST_UPD: begin
        sb_d   = sb_new;
        a_d    = a_q + pi_q;
        scur_d = cfg_i.fit_mode ? sb_new : p0_q - pi_q;
        qcur_d = cfg_i.fit_mode ? qb_q : BW'(i_q);
      end
      ST_BND: begin
        mul_a = AW'(cfg_i.noise_bound);
        mul_b = qcur_q;
      end
      ST_BND_W: begin
        bound_d = prod;
        j_d     = IW'(1);
      end
      ST_RD_J: begin
        hist_raddr = hist_addr(wi_q, j_q, size);
      end
      ST_GOT_J: begin
        mul_a = p0_q - rd_pos;
        mul_b = qcur_q;
      end
      ST_MUL_J: begin
        t1_d  = prod;
        mul_a = scur_q;
        mul_b = BW'(j_q);
      end
      ST_CMP_J: begin
        j_d = j_q + IW'(1);
      end
      ST_ACC: begin
        sacc_d = scur_q;
        qacc_d = qcur_q;
        i_d    = i_q + IW'(1);
      end
      ST_VEL: begin
        mul_a = sacc_q[AW-1] ? -sacc_q : sacc_q;
        mul_b = BW'(cfg_i.sample_rate);
        neg_d = sacc_q[AW-1];
      end
      ST_VEL_W: begin
        num_d = prod + PRW'(qacc_q >> 1);
        rem_d = '0;
        quo_d = '0;
        big_d = 1'b0;
        cnt_d = DCW'(PRW);
      end
      ST_DIV: begin
        num_d = num_q << 1;
        big_d = big_q | quo_q[VEL_WIDTH-1];
        cnt_d = cnt_q - DCW'(1);
        if (rem_sh >= {1'b0, qacc_q}) begin
          rem_d = BW'(rem_sh - {1'b0, qacc_q});
          quo_d = {quo_q[VEL_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[BW-1:0];
          quo_d = {quo_q[VEL_WIDTH-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        if (neg_q) begin
          vel_d = ovf ? {1'b1, {(VEL_WIDTH-1){1'b0}}} : -quo_q;
        end else begin
          vel_d = ovf ? {1'b0, {(VEL_WIDTH-1){1'b1}}} : quo_q;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wi_q    <= '0;
    end else begin
      state_q <= state_d;
      wi_q    <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d;
    p0_q <= p0_d; pi_q <= pi_d; a_q <= a_d; sb_q <= sb_d;
    scur_q <= scur_d; sacc_q <= sacc_d;
    qb_q <= qb_d; t_q <= t_d; qcur_q <= qcur_d; qacc_q <= qacc_d;
    bound_q <= bound_d; t1_q <= t1_d; num_q <= num_d; rem_q <= rem_d;
    quo_q <= quo_d; big_q <= big_d; neg_q <= neg_d; cnt_q <= cnt_d;
    vel_q <= vel_d;
  end

  assign velocity_o = vel_q;

endmodule

`default_nettype wire

@@ sv/adaptive_window_velocity_estimator.sv @@
// ----------------------------------------------------------------------------
// adaptive_window_velocity_estimator
// First-order adaptive windowing velocity estimate from position samples.
//
//   channel | signals                          | dir
//   cfg     | cfg_we_i cfg_idx_i cfg_data_i    | in
//   in      | in_valid_i in_ready_o position_i | in
//   out     | out_valid_o out_ready_i velocity_o| out
//
// One word at a time; no new position is taken until the last result is taken.
// Each word runs the write-index wrap (after a length change the index steps
// down by the window size until in range), a window search that grows until
// full or a sample breaks the noise bound, then rate scale and divide.
// Reset clears config to defaults, history to zero via valid bits.
// A stalled result holds in_ready_o low until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_window_velocity_estimator
  import awve_pkg::*;
#(
  parameter int unsigned MAX_WINDOW     = MAX_WINDOW_DEF,
  parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [CFG_WIDTH-1:0]      cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [POSITION_WIDTH-1:0] position_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [VEL_WIDTH-1:0]           velocity_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIT_MODE: cfg_q.fit_mode      <= cfg_data_i[0];
        CFG_WIN_LEN:  cfg_q.window_length <= cfg_data_i[LEN_WIDTH-1:0];
        CFG_NOISE:    cfg_q.noise_bound   <= cfg_data_i[NOISE_WIDTH-1:0];
        CFG_RATE:     cfg_q.sample_rate   <= cfg_data_i[RATE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  awve_core #(
    .MAX_WINDOW     (MAX_WINDOW),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .velocity_o  (velocity_o)
  );

endmodule

`default_nettype wire

@@ sv/awve_chk.sv @@
// ----------------------------------------------------------------------------
// awve_chk
// Port-level checks on the estimator handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_window_velocity_estimator_defines.svh"

module awve_chk
  import awve_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      cfg_we_i,
  input wire logic [1:0]                cfg_idx_i,
  input wire logic [CFG_WIDTH-1:0]      cfg_data_i,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [POSITION_WIDTH-1:0] position_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [VEL_WIDTH-1:0]      velocity_o
);

  `AWVE_ASSERT_IMP(a_excl, out_valid_o, !in_ready_o)
  `AWVE_ASSERT_NXT(a_busy, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o)
  `AWVE_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(velocity_o))
  `AWVE_ASSERT_NXT(a_free, out_valid_o && out_ready_i, in_ready_o)

endmodule

bind adaptive_window_velocity_estimator awve_chk #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_awve_chk (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Adaptive window velocity estimator testbench
// Drives position words through a directed table and then random ramps and
// noise under changing settings. The table fixes some expected velocities;
// a behavioral estimator predicts the rest; each word out is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import awve_pkg::*;

  localparam int unsigned LIMIT = 2000000;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [30:0] data;
    logic [31:0] pos;
    bit          known;
    logic [31:0] vexp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] velocity_o;

  longint      hist [16];
  int          wr_ptr;
  bit          m_fit;
  int          m_len;
  longint      m_noise;
  longint      m_rate;
  logic [31:0] velocity_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          tx_idle_pct = 18;
  int          rx_idle_pct = 48;

  adaptive_window_velocity_estimator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .velocity_o (velocity_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (velocity_q.size() == 0) begin
        $display("%0t: unexpected velocity word %h", $realtime, velocity_o);
        errors++;
      end else begin
        if (velocity_o !== velocity_q[0]) begin
          $display("%0t: velocity expected %h actual %h", $realtime, velocity_q[0],
                   velocity_o);
          errors++;
        end
        void'(velocity_q.pop_front());
      end
    end
  end

  function automatic longint sample_back(int size, int back);
    return hist[(wr_ptr + size - (back % size)) % size];
  endfunction

  function automatic logic [31:0] scale_velocity(longint s, longint q);
    longint unsigned m, quo, rem, mv;
    m = (s < 0) ? -s : s;
    quo = m / q;
    rem = m % q;
    if (m_rate == 0) return '0;
    if (quo >= 64'h1_0000_0000) mv = 64'h1_0000_0000;
    else mv = quo * m_rate + (rem * m_rate + q / 2) / q;
    if (s < 0) return (mv >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(mv));
    return (mv > 64'h7fff_ffff) ? 32'h7fff_ffff : 32'(mv);
  endfunction

  function automatic logic [31:0] estimate_velocity(logic [31:0] pos);
    int          size;
    longint      p0, s, q, dev;
    bit          bad;
    logic [31:0] v;
    size = (m_len < 2) ? 2 : (m_len > 16) ? 16 : m_len;
    v = '0;
    wr_ptr = (wr_ptr + 1) % size;
    hist[wr_ptr] = longint'(signed'(pos));
    p0 = hist[wr_ptr];
    for (int i = 1; i < size; i++) begin
      if (m_fit) begin
        s = 0;
        for (int l = 0; l <= i; l++) s += longint'(i - 2 * l) * sample_back(size, l);
        q = i * (i + 1) * (i + 2) / 6;
      end else begin
        s = p0 - sample_back(size, i);
        q = i;
      end
      bad = 1'b0;
      for (int j = 1; j < i; j++) begin
        dev = q * (p0 - sample_back(size, j)) - s * j;
        if (dev < 0) dev = -dev;
        if (dev > q * m_noise) bad = 1'b1;
      end
      if (bad) break;
      v = scale_velocity(s, q);
    end
    return v;
  endfunction

  task automatic send_word(logic [31:0] pos, bit known, logic [31:0] vexp);
    logic [31:0] v;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    v = estimate_velocity(pos);
    velocity_q.push_back(known ? vexp : v);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (velocity_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [30:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FIT_MODE: m_fit = data[0];
      CFG_WIN_LEN:  m_len = data[4:0];
      CFG_NOISE:    m_noise = data;
      CFG_RATE:     m_rate = data[19:0];
      default: ;
    endcase
  endtask

  task automatic random_settings;
    drain();
    write_reg(CFG_FIT_MODE, 31'($urandom_range(1)));
    write_reg(CFG_WIN_LEN, ($urandom_range(9) == 0) ? 31'($urandom_range(31))
                                                      : 31'($urandom_range(2, 16)));
    case ($urandom_range(3))
      0: write_reg(CFG_NOISE, 31'($urandom_range(16)));
      1: write_reg(CFG_NOISE, 31'($urandom_range(4000)));
      2: write_reg(CFG_NOISE, 31'($urandom_range(1 << 20)));
      default: write_reg(CFG_NOISE, 31'($urandom));
    endcase
    case ($urandom_range(4))
      0: write_reg(CFG_RATE, 31'($urandom_range(1)));
      1: write_reg(CFG_RATE, 31'd1000000);
      default: write_reg(CFG_RATE, 31'($urandom_range(1, 1000000)));
    endcase
  endtask

  task automatic random_words(int n);
    longint base, slope, jitter;
    base = longint'(signed'(32'($urandom)));
    slope = longint'($urandom_range(1 << 21)) - (1 << 20);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 7) begin
        jitter = (m_noise < 64) ? longint'($urandom_range(m_noise))
                                : longint'($urandom_range(64));
        base += slope;
        if ($urandom_range(19) == 0)
          slope = longint'($urandom_range(1 << 21)) - (1 << 20);
        send_word(32'(base + (($urandom_range(1)) ? jitter : -jitter)), 1'b0, '0);
      end else begin
        send_word($urandom, 1'b0, '0);
      end
    end
  endtask

  row_t rows [] = '{
    '{0, CFG_FIT_MODE, 31'd0, 32'h0000_0000, 1, 32'h0000_0000},
    '{0, CFG_FIT_MODE, 31'd0, 32'h7fff_ffff, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h8000_0000, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0001_0000, 0, 32'h0},
    '{1, CFG_NOISE, 31'h7fff_ffff, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0002_0000, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0003_0000, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0004_0000, 0, 32'h0},
    '{1, CFG_FIT_MODE, 31'd0, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0005_0000, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'hffff_0000, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd2, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0010_0000, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd16, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0011_0000, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0012_0000, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd0, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0013_0000, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd31, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0014_0000, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd1, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0015_0000, 0, 32'h0},
    '{1, CFG_RATE, 31'd0, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h1234_5678, 1, 32'h0000_0000},
    '{1, CFG_RATE, 31'd1000000, 32'h0, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd4, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h8000_0000, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h7fff_ffff, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h8000_0000, 0, 32'h0},
    '{1, CFG_NOISE, 31'd0, 32'h0, 0, 32'h0},
    '{1, CFG_FIT_MODE, 31'd1, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0000_0100, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0000_0200, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'h0000_0301, 0, 32'h0},
    '{1, CFG_WIN_LEN, 31'd15, 32'h0, 0, 32'h0},
    '{1, CFG_RATE, 31'd1000, 32'h0, 0, 32'h0},
    '{1, CFG_NOISE, 31'd7, 32'h0, 0, 32'h0},
    '{0, CFG_FIT_MODE, 31'd0, 32'hdead_beef, 0, 32'h0}
  };

  initial begin
    foreach (hist[n]) hist[n] = 0;
    wr_ptr = 0;
    m_fit = CFG_RESET.fit_mode;
    m_len = CFG_RESET.window_length;
    m_noise = CFG_RESET.noise_bound;
    m_rate = CFG_RESET.sample_rate;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        drain();
        write_reg(rows[r].idx, rows[r].data);
      end else begin
        send_word(rows[r].pos, rows[r].known, rows[r].vexp);
      end
    end
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 48 : 0;
      rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 18 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        random_settings();
        random_words(40);
      end
    end
    drain();
    repeat (1000) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
